// ----- rtl/tpcs_pkg.sv -----
package tpcs_pkg;

    // Fixed point of the vertex coordinates and size of the pixel grid
    localparam int COORD_FRAC_BITS = 4;
    localparam int CANVAS_DIM_BITS = 10;

    // Field widths
    localparam int VERT_W  = 14;
    localparam int COLOR_W = 24;
    localparam int PIXEL_W = 10;
    localparam int ADDR_W  = 32;
    localparam int PITCH_W = 16;
    localparam int CH_W    = 8;

    // Pixel bits in use and width of the pixel point in coordinate fixed point
    localparam int PIX_W = (CANVAS_DIM_BITS < PIXEL_W) ? CANVAS_DIM_BITS : PIXEL_W;
    localparam int P_W   = PIX_W + COORD_FRAC_BITS;
    localparam int C_W   = (VERT_W > P_W) ? VERT_W : P_W;

    // Difference, product, edge and edge-AB-to-P widths (signed)
    localparam int D_W = C_W + 1;
    localparam int M_W = 2 * D_W;
    localparam int E_W = M_W + 1;
    localparam int A_W = E_W + 2;

    // Area magnitude and divider remainder widths (unsigned)
    localparam int S_W = 2 * VERT_W + 1;
    localparam int R_W = S_W + 1;

    // Barycentric weights: WEIGHT_BITS fraction bits, one more for the value one
    localparam int WEIGHT_BITS = 16;
    localparam int W_W         = WEIGHT_BITS + 1;
    localparam logic [W_W-1:0] WEIGHT_ONE = W_W'(1) << WEIGHT_BITS;

    // Blend products and sums
    localparam int BP_W = CH_W + W_W;
    localparam int BS_W = BP_W + 2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH  = CFG_IDX_W'(1);

    localparam logic [PITCH_W-1:0] ROW_PITCH_RESET = PITCH_W'(4096);

    // Stream data widths
    localparam int IN_DATA_W  = 176;
    localparam int OUT_DATA_W = 56;

    // Per-item data that rides along with the weight computation
    typedef struct packed {
        logic               hit;
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] color_a;
        logic [COLOR_W-1:0] color_b;
        logic [COLOR_W-1:0] color_c;
    } side_t;

endpackage

// ----- rtl/tpcs_setup.sv -----
module tpcs_setup (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [tpcs_pkg::VERT_W-1:0] vert_a_x,
    input  logic [tpcs_pkg::VERT_W-1:0] vert_a_y,
    input  logic [tpcs_pkg::VERT_W-1:0] vert_b_x,
    input  logic [tpcs_pkg::VERT_W-1:0] vert_b_y,
    input  logic [tpcs_pkg::VERT_W-1:0] vert_c_x,
    input  logic [tpcs_pkg::VERT_W-1:0] vert_c_y,
    input  logic [tpcs_pkg::COLOR_W-1:0] color_a,
    input  logic [tpcs_pkg::COLOR_W-1:0] color_b,
    input  logic [tpcs_pkg::COLOR_W-1:0] color_c,
    input  logic [tpcs_pkg::PIXEL_W-1:0] pixel_col,
    input  logic [tpcs_pkg::PIXEL_W-1:0] pixel_row,
    input  logic [tpcs_pkg::ADDR_W-1:0]  frame_base,
    input  logic [tpcs_pkg::PITCH_W-1:0] row_pitch,
    output logic                        out_valid,
    output tpcs_pkg::side_t             out_side,
    output logic [tpcs_pkg::S_W-1:0]    out_area,
    output logic [tpcs_pkg::S_W-1:0]    out_ea,
    output logic [tpcs_pkg::S_W-1:0]    out_eb
);
    import tpcs_pkg::*;

    function automatic logic signed [D_W-1:0] sdiff(input logic [C_W-1:0] a,
                                                   input logic [C_W-1:0] b);
        sdiff = $signed({1'b0, a}) - $signed({1'b0, b});
    endfunction

    // Coordinates at a common width
    logic [C_W-1:0] ax, ay, bx, by, cx, cy, px, py;
    logic [PIX_W-1:0] col, row;
    logic [VERT_W-1:0] minx, maxx, miny, maxy;
    logic box;

    // Stage 1 registers
    logic                      v1_reg;
    logic signed [D_W-1:0]     d_reg [12];
    logic signed [D_W-1:0]     d_next [12];
    logic                      box1_reg;
    logic [COLOR_W-1:0]        ca1_reg, cb1_reg, cc1_reg;
    logic [ADDR_W-1:0]         rowoff1_reg, basecol1_reg;

    // Stage 2 registers
    logic                      v2_reg;
    logic signed [M_W-1:0]     p_reg [6];
    logic                      box2_reg;
    logic [COLOR_W-1:0]        ca2_reg, cb2_reg, cc2_reg;
    logic [ADDR_W-1:0]         addr2_reg;

    // Stage 3 registers
    logic                      v3_reg;
    logic signed [E_W-1:0]     abc3_reg, bcp3_reg, cap3_reg;
    logic                      box3_reg;
    logic [COLOR_W-1:0]        ca3_reg, cb3_reg, cc3_reg;
    logic [ADDR_W-1:0]         addr3_reg;

    // Stage 4 logic
    logic signed [A_W-1:0]     abp;
    logic signed [A_W-1:0]     neg_abc, neg_bcp, neg_cap;
    logic                      hit;

    // Widen inputs and place the pixel point in coordinate fixed point
    always_comb
    begin
        col  = pixel_col[PIX_W-1:0];
        row  = pixel_row[PIX_W-1:0];
        ax   = C_W'(vert_a_x);
        ay   = C_W'(vert_a_y);
        bx   = C_W'(vert_b_x);
        by   = C_W'(vert_b_y);
        cx   = C_W'(vert_c_x);
        cy   = C_W'(vert_c_y);
        px   = C_W'({col, {COORD_FRAC_BITS{1'b0}}});
        py   = C_W'({row, {COORD_FRAC_BITS{1'b0}}});
        minx = vert_a_x;
        maxx = vert_a_x;
        miny = vert_a_y;
        maxy = vert_a_y;
        if (vert_b_x < minx) minx = vert_b_x;
        if (vert_c_x < minx) minx = vert_c_x;
        if (vert_b_x > maxx) maxx = vert_b_x;
        if (vert_c_x > maxx) maxx = vert_c_x;
        if (vert_b_y < miny) miny = vert_b_y;
        if (vert_c_y < miny) miny = vert_c_y;
        if (vert_b_y > maxy) maxy = vert_b_y;
        if (vert_c_y > maxy) maxy = vert_c_y;
        box = (C_W'(col) >= C_W'(minx >> COORD_FRAC_BITS)) && (px < C_W'(maxx)) &&
              (C_W'(row) >= C_W'(miny >> COORD_FRAC_BITS)) && (py < C_W'(maxy));
    end

    // Edge-function differences: area, edge BC to P, edge CA to P
    always_comb
    begin
        d_next[0]  = sdiff(bx, ax);
        d_next[1]  = sdiff(cy, ay);
        d_next[2]  = sdiff(by, ay);
        d_next[3]  = sdiff(cx, ax);
        d_next[4]  = sdiff(cx, bx);
        d_next[5]  = sdiff(py, by);
        d_next[6]  = sdiff(cy, by);
        d_next[7]  = sdiff(px, bx);
        d_next[8]  = sdiff(ax, cx);
        d_next[9]  = sdiff(py, cy);
        d_next[10] = sdiff(ay, cy);
        d_next[11] = sdiff(px, cx);
    end

    // Value of edge AB to P and coverage decision
    always_comb
    begin
        abp     = A_W'(abc3_reg) - A_W'(bcp3_reg) - A_W'(cap3_reg);
        neg_abc = -A_W'(abc3_reg);
        neg_bcp = -A_W'(bcp3_reg);
        neg_cap = -A_W'(cap3_reg);
        hit     = v3_reg && box3_reg && (abc3_reg < 0) && (bcp3_reg <= 0) &&
                  (cap3_reg <= 0) && (abp <= 0);
    end

    // Hold valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            out_valid <= v3_reg;
        end
    end

    // Advance payload through the four setup stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg        <= d_next;
            box1_reg     <= box;
            ca1_reg      <= color_a;
            cb1_reg      <= color_b;
            cc1_reg      <= color_c;
            rowoff1_reg  <= ADDR_W'(row_pitch) * ADDR_W'(row);
            basecol1_reg <= frame_base + ADDR_W'({col, 2'b00});

            for (int i = 0; i < 6; i++)
            begin
                p_reg[i] <= M_W'(d_reg[2*i]) * M_W'(d_reg[2*i+1]);
            end
            box2_reg  <= box1_reg;
            ca2_reg   <= ca1_reg;
            cb2_reg   <= cb1_reg;
            cc2_reg   <= cc1_reg;
            addr2_reg <= basecol1_reg + rowoff1_reg;

            abc3_reg  <= E_W'(p_reg[0]) - E_W'(p_reg[1]);
            bcp3_reg  <= E_W'(p_reg[2]) - E_W'(p_reg[3]);
            cap3_reg  <= E_W'(p_reg[4]) - E_W'(p_reg[5]);
            box3_reg  <= box2_reg;
            ca3_reg   <= ca2_reg;
            cb3_reg   <= cb2_reg;
            cc3_reg   <= cc2_reg;
            addr3_reg <= addr2_reg;

            out_side.hit     <= hit;
            out_side.addr    <= addr3_reg;
            out_side.color_a <= ca3_reg;
            out_side.color_b <= cb3_reg;
            out_side.color_c <= cc3_reg;
            out_area         <= neg_abc[S_W-1:0];
            out_ea           <= neg_bcp[S_W-1:0];
            out_eb           <= neg_cap[S_W-1:0];
        end
    end

endmodule

// ----- rtl/tpcs_div.sv -----
module tpcs_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  tpcs_pkg::side_t          in_side,
    input  logic [tpcs_pkg::S_W-1:0] in_area,
    input  logic [tpcs_pkg::S_W-1:0] in_ea,
    input  logic [tpcs_pkg::S_W-1:0] in_eb,
    output logic                     out_valid,
    output tpcs_pkg::side_t          out_side,
    output logic [tpcs_pkg::W_W-1:0] out_wa,
    output logic [tpcs_pkg::W_W-1:0] out_wb
);
    import tpcs_pkg::*;

    // One restoring compare-subtract: quotient bit on top, new remainder below
    function automatic logic [R_W:0] div_step(input logic [R_W-1:0] t,
                                              input logic [S_W-1:0] s);
        logic [R_W-1:0] se;
        se = {1'b0, s};
        if (t >= se)
            div_step = {1'b1, t - se};
        else
            div_step = {1'b0, t};
    endfunction

    // One stage per quotient bit, two lanes sharing the divisor
    logic               v_reg  [W_W];
    side_t              sd_reg [W_W];
    logic [S_W-1:0]     s_reg  [W_W];
    logic [R_W-1:0]     ra_reg [W_W];
    logic [R_W-1:0]     rb_reg [W_W];
    logic [W_W-1:0]     qa_reg [W_W];
    logic [W_W-1:0]     qb_reg [W_W];
    logic [R_W-1:0]     ra_next [W_W];
    logic [R_W-1:0]     rb_next [W_W];
    logic [W_W-1:0]     qa_next [W_W];
    logic [W_W-1:0]     qb_next [W_W];

    // Form each stage's trial remainder and quotient bit
    always_comb
    begin
        logic [R_W:0] sa;
        logic [R_W:0] sb;
        sa = div_step({1'b0, in_ea}, in_area);
        sb = div_step({1'b0, in_eb}, in_area);
        ra_next[0] = sa[R_W-1:0];
        rb_next[0] = sb[R_W-1:0];
        qa_next[0] = W_W'(sa[R_W]);
        qb_next[0] = W_W'(sb[R_W]);
        for (int k = 1; k < W_W; k++)
        begin
            sa = div_step({ra_reg[k-1][R_W-2:0], 1'b0}, s_reg[k-1]);
            sb = div_step({rb_reg[k-1][R_W-2:0], 1'b0}, s_reg[k-1]);
            ra_next[k] = sa[R_W-1:0];
            rb_next[k] = sb[R_W-1:0];
            qa_next[k] = {qa_reg[k-1][W_W-2:0], sa[R_W]};
            qb_next[k] = {qb_reg[k-1][W_W-2:0], sb[R_W]};
        end
    end

    // Hold valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < W_W; k++)
                v_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k < W_W; k++)
                v_reg[k] <= v_reg[k-1];
        end
    end

    // Advance remainders, quotients and ride-along data
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sd_reg[0] <= in_side;
            s_reg[0]  <= in_area;
            for (int k = 1; k < W_W; k++)
            begin
                sd_reg[k] <= sd_reg[k-1];
                s_reg[k]  <= s_reg[k-1];
            end
            ra_reg <= ra_next;
            rb_reg <= rb_next;
            qa_reg <= qa_next;
            qb_reg <= qb_next;
        end
    end

    assign out_valid = v_reg[W_W-1];
    assign out_side  = sd_reg[W_W-1];
    assign out_wa    = qa_reg[W_W-1];
    assign out_wb    = qb_reg[W_W-1];

endmodule

// ----- rtl/tpcs_blend.sv -----
module tpcs_blend (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  tpcs_pkg::side_t           in_side,
    input  logic [tpcs_pkg::W_W-1:0]  in_wa,
    input  logic [tpcs_pkg::W_W-1:0]  in_wb,
    output logic                      out_valid,
    output logic                      covered,
    output logic [tpcs_pkg::ADDR_W-1:0] write_address,
    output logic [tpcs_pkg::CH_W-1:0] blue,
    output logic [tpcs_pkg::CH_W-1:0] green,
    output logic [tpcs_pkg::CH_W-1:0] red
);
    import tpcs_pkg::*;

    logic [W_W-1:0]  wc;

    // Product stage: index is channel * 3 + vertex
    logic            v1_reg;
    logic            hit1_reg;
    logic [ADDR_W-1:0] addr1_reg;
    logic [BP_W-1:0] prod_reg [9];
    logic [BS_W-1:0] sum [3];

    assign wc = WEIGHT_ONE - in_wa - in_wb;

    // Sum the weighted channels
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            sum[c] = BS_W'(prod_reg[3*c]) + BS_W'(prod_reg[3*c+1]) +
                     BS_W'(prod_reg[3*c+2]);
        end
    end

    // Hold valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= in_valid;
            out_valid <= v1_reg;
        end
    end

    // Multiply channels by weights, then sum, truncate and zero the payload of uncovered pixels
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit1_reg  <= in_side.hit;
            addr1_reg <= in_side.addr;
            for (int c = 0; c < 3; c++)
            begin
                prod_reg[3*c]   <= BP_W'(in_side.color_a[CH_W*c +: CH_W]) * BP_W'(in_wa);
                prod_reg[3*c+1] <= BP_W'(in_side.color_b[CH_W*c +: CH_W]) * BP_W'(in_wb);
                prod_reg[3*c+2] <= BP_W'(in_side.color_c[CH_W*c +: CH_W]) * BP_W'(wc);
            end

            covered <= hit1_reg;
            if (hit1_reg)
            begin
                write_address <= addr1_reg;
                blue          <= sum[0][WEIGHT_BITS +: CH_W];
                green         <= sum[1][WEIGHT_BITS +: CH_W];
                red           <= sum[2][WEIGHT_BITS +: CH_W];
            end
            else
            begin
                write_address <= '0;
                blue          <= '0;
                green         <= '0;
                red           <= '0;
            end
        end
    end

endmodule

// ----- rtl/triangle_pixel_coverage_shade_unit.sv -----
// Pipeline from an input transfer to its result: 4 setup stages, 17 divider stages at
// one weight bit each, 2 blend stages.
// Throughput: one pixel per cycle; the whole pipeline holds while the output register
// waits on m_axis_tready.
// Reset clears all valid bits and sets frame_base to 0 and row_pitch to 4096.
module triangle_pixel_coverage_shade_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    // vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x, vert_c_y, color_a, color_b,
    // color_c, pixel_col, pixel_row
    input  logic [tpcs_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // write_address, blue, green, red
    output logic [tpcs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // covered
    output logic                              m_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tpcs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tpcs_pkg::ADDR_W-1:0]       cfg_data
);
    import tpcs_pkg::*;

    logic [ADDR_W-1:0]  frame_base_reg;
    logic [PITCH_W-1:0] row_pitch_reg;
    logic               en;

    logic               su_valid;
    side_t              su_side;
    logic [S_W-1:0]     su_area, su_ea, su_eb;
    logic               dv_valid;
    side_t              dv_side;
    logic [W_W-1:0]     dv_wa, dv_wb;
    logic               covered;
    logic [ADDR_W-1:0]  write_address;
    logic [CH_W-1:0]    blue, green, red;

    // Advance the pipeline whenever the output register is free or drains
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign cfg_ready     = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_base_reg <= '0;
            row_pitch_reg  <= ROW_PITCH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FRAME_BASE: frame_base_reg <= cfg_data;
                REG_ROW_PITCH:  row_pitch_reg  <= cfg_data[PITCH_W-1:0];
                default:        ;
            endcase
        end
    end

    tpcs_setup u_setup (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (s_axis_tvalid),
        .vert_a_x   (s_axis_tdata[13:0]),
        .vert_a_y   (s_axis_tdata[27:14]),
        .vert_b_x   (s_axis_tdata[41:28]),
        .vert_b_y   (s_axis_tdata[55:42]),
        .vert_c_x   (s_axis_tdata[69:56]),
        .vert_c_y   (s_axis_tdata[83:70]),
        .color_a    (s_axis_tdata[107:84]),
        .color_b    (s_axis_tdata[131:108]),
        .color_c    (s_axis_tdata[155:132]),
        .pixel_col  (s_axis_tdata[165:156]),
        .pixel_row  (s_axis_tdata[175:166]),
        .frame_base (frame_base_reg),
        .row_pitch  (row_pitch_reg),
        .out_valid  (su_valid),
        .out_side   (su_side),
        .out_area   (su_area),
        .out_ea     (su_ea),
        .out_eb     (su_eb)
    );

    tpcs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (su_valid),
        .in_side   (su_side),
        .in_area   (su_area),
        .in_ea     (su_ea),
        .in_eb     (su_eb),
        .out_valid (dv_valid),
        .out_side  (dv_side),
        .out_wa    (dv_wa),
        .out_wb    (dv_wb)
    );

    tpcs_blend u_blend (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (dv_valid),
        .in_side       (dv_side),
        .in_wa         (dv_wa),
        .in_wb         (dv_wb),
        .out_valid     (m_axis_tvalid),
        .covered       (covered),
        .write_address (write_address),
        .blue          (blue),
        .green         (green),
        .red           (red)
    );

    assign m_axis_tuser = covered;
    assign m_axis_tdata = {red, green, blue, write_address};

    // An uncovered pixel carries an all-zero payload
    a_uncovered_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("uncovered pixel with nonzero payload");

    // A stalled output blocks new input transfers
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while output stalled");

    // A row pitch write lands in the register
    a_pitch_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && cfg_index == REG_ROW_PITCH |=>
        row_pitch_reg == $past(cfg_data[PITCH_W-1:0]))
        else $error("row pitch write lost");

endmodule
